// ----- src/fpe_pkg.sv -----
package fpe_pkg;

  localparam int TS_W        = 32;
  localparam int FT_W        = 20;
  localparam int LIM_W       = 21;
  localparam int SUM_W       = 26;
  localparam int AVG_W       = 25;
  localparam int NEXT_W      = 26;
  localparam int AVG_ACC_W   = 31;
  localparam int VAR_ACC_W   = 30;
  localparam int CNT_W       = 5;

  // Number of accepted intervals per average update is 2^LOG2_BATCH.
  localparam int LOG2_BATCH  = 4;

  localparam int LIMIT_SHIFT = 2;
  localparam int CLAMP_SHIFT = 6;
  localparam int VAR_SHIFT   = 12;
  localparam int AVG_SHIFT   = 5;
  localparam int DEV_SHIFT   = 4;

  typedef logic [TS_W-1:0]      stamp_t;
  typedef logic [FT_W-1:0]      ft_t;
  typedef logic [LIM_W-1:0]     lim_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [AVG_W-1:0]     avg_t;
  typedef logic [NEXT_W-1:0]    next_t;
  typedef logic [AVG_ACC_W-1:0] avg_acc_t;
  typedef logic [VAR_ACC_W-1:0] var_acc_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t BATCH_COUNT = cnt_t'(1 << LOG2_BATCH);
  localparam ft_t  FT_RESET    = ft_t'(16666);

  // Interval stage register contents.
  typedef struct packed {
    logic valid;
    logic ok;
    lim_t interval;
  } fpe_item_t;

  // Reinitialisation request: asserted with the frame time to start from.
  typedef struct packed {
    logic load;
    ft_t  frame_time;
  } fpe_init_t;

  function automatic avg_t initial_average(input ft_t ft);
    return avg_t'(ft) << LOG2_BATCH;
  endfunction

  function automatic next_t clamp_high(input ft_t ft);
    return next_t'(lim_t'(ft) + lim_t'(ft >> CLAMP_SHIFT)) << LOG2_BATCH;
  endfunction

  function automatic next_t clamp_low(input ft_t ft);
    return next_t'(ft - (ft >> CLAMP_SHIFT)) << LOG2_BATCH;
  endfunction

endpackage

// ----- src/fpe_interval.sv -----
module fpe_interval (
  input  logic              clk,
  input  logic              rst,
  input  fpe_pkg::fpe_init_t init,
  input  fpe_pkg::ft_t      frame_time,
  input  logic              accept,
  input  logic              drain,
  input  fpe_pkg::stamp_t   timestamp,
  output fpe_pkg::fpe_item_t item
);

  fpe_pkg::stamp_t previous_stamp;
  fpe_pkg::stamp_t delta;
  fpe_pkg::lim_t   limit;
  logic            valid;
  logic            ok;
  fpe_pkg::lim_t   interval;

  // The interval depends only on consecutive stamps, so it is formed a stage
  // ahead of the averaging loop.
  always_comb begin
    delta = timestamp - previous_stamp;
    limit = fpe_pkg::lim_t'(frame_time) + fpe_pkg::lim_t'(frame_time >> fpe_pkg::LIMIT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      previous_stamp <= '0;
    end else begin
      if (accept) begin
        valid          <= 1'b1;
        previous_stamp <= timestamp;
      end else if (drain) begin
        valid <= 1'b0;
      end
      if (init.load) begin
        previous_stamp <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= delta < fpe_pkg::stamp_t'(limit);
      interval <= fpe_pkg::lim_t'(delta);
    end
  end

  assign item = '{valid: valid, ok: ok, interval: interval};

endmodule

// ----- src/fpe_average.sv -----
module fpe_average (
  input  logic               clk,
  input  logic               rst,
  input  fpe_pkg::fpe_init_t init,
  input  fpe_pkg::ft_t       frame_time,
  input  logic               step,
  input  fpe_pkg::lim_t      interval,
  output fpe_pkg::avg_t      average,
  output fpe_pkg::avg_t      variation
);

  fpe_pkg::sum_t     interval_sum;
  fpe_pkg::cnt_t     intervals_left;

  fpe_pkg::sum_t     sum_add;
  fpe_pkg::cnt_t     left_dec;
  fpe_pkg::avg_acc_t avg_x31;
  fpe_pkg::avg_acc_t avg_raw;
  fpe_pkg::next_t    avg_unclamped;
  fpe_pkg::next_t    hi;
  fpe_pkg::next_t    lo;
  fpe_pkg::next_t    avg_clamped;
  fpe_pkg::avg_t     average_next;
  fpe_pkg::avg_t     diff;
  fpe_pkg::var_acc_t var_x15;
  fpe_pkg::var_acc_t var_raw;
  fpe_pkg::avg_t     variation_next;
  fpe_pkg::avg_t     init_average;

  always_comb begin
    sum_add  = interval_sum + fpe_pkg::sum_t'(interval);
    left_dec = intervals_left - fpe_pkg::cnt_t'(1);

    // Rounded 31/32 average: 31*x is formed as 32*x - x.
    avg_x31 = (fpe_pkg::avg_acc_t'(average) << fpe_pkg::AVG_SHIFT)
            - fpe_pkg::avg_acc_t'(average);
    avg_raw = avg_x31 + fpe_pkg::avg_acc_t'(sum_add)
            + fpe_pkg::avg_acc_t'(1 << (fpe_pkg::AVG_SHIFT - 1));
    avg_unclamped = fpe_pkg::next_t'(avg_raw >> fpe_pkg::AVG_SHIFT);

    hi = fpe_pkg::clamp_high(frame_time);
    lo = fpe_pkg::clamp_low(frame_time);
    if (avg_unclamped > hi) begin
      avg_clamped = hi;
    end else if (avg_unclamped < lo) begin
      avg_clamped = lo;
    end else begin
      avg_clamped = avg_unclamped;
    end
    average_next = fpe_pkg::avg_t'(avg_clamped);

    if (average_next >= average) begin
      diff = average_next - average;
    end else begin
      diff = average - average_next;
    end

    // Rounded 15/16 average of the absolute change.
    var_x15 = (fpe_pkg::var_acc_t'(variation) << fpe_pkg::DEV_SHIFT)
            - fpe_pkg::var_acc_t'(variation);
    var_raw = var_x15 + fpe_pkg::var_acc_t'(diff)
            + fpe_pkg::var_acc_t'(1 << (fpe_pkg::DEV_SHIFT - 1));
    variation_next = fpe_pkg::avg_t'(var_raw >> fpe_pkg::DEV_SHIFT);

    init_average = fpe_pkg::initial_average(init.frame_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_sum   <= '0;
      intervals_left <= fpe_pkg::BATCH_COUNT;
      average        <= fpe_pkg::initial_average(fpe_pkg::FT_RESET);
      variation      <= fpe_pkg::initial_average(fpe_pkg::FT_RESET) >> fpe_pkg::VAR_SHIFT;
    end else if (init.load) begin
      interval_sum   <= '0;
      intervals_left <= fpe_pkg::BATCH_COUNT;
      average        <= init_average;
      variation      <= init_average >> fpe_pkg::VAR_SHIFT;
    end else if (step) begin
      if (left_dec == '0) begin
        interval_sum   <= '0;
        intervals_left <= fpe_pkg::BATCH_COUNT;
        average        <= average_next;
        variation      <= variation_next;
      end else begin
        interval_sum   <= sum_add;
        intervals_left <= left_dec;
      end
    end
  end

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    intervals_left != '0 && intervals_left <= fpe_pkg::BATCH_COUNT)
    else $error("interval countdown out of range");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    intervals_left == fpe_pkg::BATCH_COUNT |-> interval_sum == '0)
    else $error("interval sum not cleared at start of batch");

  a_avg_band: assert property (@(posedge clk) disable iff (rst)
    fpe_pkg::next_t'(average) <= hi && fpe_pkg::next_t'(average) >= lo)
    else $error("average outside the clamp band");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step && !init.load |=> $stable(average) && $stable(variation))
    else $error("average changed without an item");

endmodule

// ----- src/frame_period_estimator.sv -----
// Smoothed frame-period estimate from per-frame microsecond timestamps. Each
// request carries a timestamp; one result comes back for every request, in
// order, holding the average period (scaled by 16) and its smoothed variation
// after that timestamp. One request is taken per clock cycle while results are
// taken as they are offered. A result is offered when its item moves from the
// interval stage into the averaging loop, whose state registers hold the
// result until it is taken. While a result waits, the interval stage can still
// hold one more request; after that the input stalls. The averaging loop forms
// its next state combinationally, so it takes an item whenever the output slot
// is free. Writing frame_time restarts the estimator from its initial state; do
// so only with no requests in flight.
module frame_period_estimator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [fpe_pkg::FT_W-1:0]  cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [fpe_pkg::TS_W-1:0]  timestamp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [fpe_pkg::AVG_W-1:0] period_average,
  output logic [fpe_pkg::AVG_W-1:0] period_variation
);

  fpe_pkg::ft_t       frame_time;
  fpe_pkg::fpe_init_t init;
  fpe_pkg::fpe_item_t item;
  logic               out_free;
  logic               advance;
  logic               accept;

  assign init     = '{load: cfg_wr_en, frame_time: cfg_wr_data};
  assign out_free = !out_valid || out_ready;
  assign advance  = item.valid && out_free;
  assign in_ready = !item.valid || out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= fpe_pkg::FT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_time <= cfg_wr_data;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  fpe_interval u_interval (
    .clk        (clk),
    .rst        (rst),
    .init       (init),
    .frame_time (frame_time),
    .accept     (accept),
    .drain      (advance),
    .timestamp  (timestamp),
    .item       (item)
  );

  // The state registers double as the result register: they change only when
  // an item moves into the free output slot, or when frame_time is written.
  fpe_average u_average (
    .clk        (clk),
    .rst        (rst),
    .init       (init),
    .frame_time (frame_time),
    .step       (advance && item.ok),
    .interval   (item.interval),
    .average    (period_average),
    .variation  (period_variation)
  );

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !item.valid |-> in_ready)
    else $error("input stalled with an empty interval stage");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item lost between interval stage and output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("waiting result overwritten");

endmodule
